### design/assert_macros.svh
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/accp_pkg.sv
// Types and constants of the CSV command line parser.
package accp_pkg;

   localparam int HDR_LEN     = 5;
   localparam int VALUE_COUNT = 5;

   localparam logic [2:0]  LAST_INDEX = 3'd6;
   localparam logic [2:0]  HDR_DONE   = 3'd5;
   localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // "start"
   localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74};

   typedef enum logic [2:0] {
      CLS_RESTART,
      CLS_NEWLINE,
      CLS_COMMA,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      byte_class_type       cls;
      logic [3:0]           digit;
      logic [HDR_LEN-1:0]   hdr_match;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } queue_head_type;

endpackage

### design/ascii_csv_command_line_parser.sv
// Top level of the CSV command line parser.
//
// Input channel (req_): one received byte per item on req_rx_byte. A newline
// ends a line, a zero byte drops the partial line. A line whose first five
// bytes are "start" commits its comma-separated decimal tokens 1 to 5 into
// the held values.
// Result channel (rsp_): one item per newline with rsp_header_ok and the five
// held values, after any update made by that line.
// Throughput: one byte per cycle, sustained while req_stall is low. Each byte
// passes a classify register, the queue (QUEUE_DEPTH entries) and the parser,
// whose per-byte multiply-by-ten accumulate is combinational.
// With the queue empty, a newline passes the classify register and the queue
// before the parser takes it and sets the registered rsp_valid.
// Reset clears the line state, the queue, the held values and the result.
// While rsp_stall holds a result, bytes other than newlines keep being parsed;
// the next newline waits in the queue, and req_stall rises once it fills.
module ascii_csv_command_line_parser
   import accp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_header_ok,
   output logic signed [31:0] rsp_strategy_id,
   output logic signed [31:0] rsp_kill_run,
   output logic signed [31:0] rsp_yaw_value,
   output logic signed [31:0] rsp_pitch_value,
   output logic signed [31:0] rsp_roll_value
);

`include "assert_macros.svh"

   logic           q_push;
   token_type      q_push_tok;
   logic           q_full;
   logic           q_pop;
   queue_head_type q_head;
   logic           nl_blocked;

   accp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .push        (q_push),
      .push_tok    (q_push_tok),
      .queue_full  (q_full)
   );

   accp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_tok (q_push_tok),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   accp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_ok   (rsp_header_ok),
      .rsp_strategy_id (rsp_strategy_id),
      .rsp_kill_run    (rsp_kill_run),
      .rsp_yaw_value   (rsp_yaw_value),
      .rsp_pitch_value (rsp_pitch_value),
      .rsp_roll_value  (rsp_roll_value)
   );

   assign nl_blocked = q_head.valid && (q_head.tok.cls == CLS_NEWLINE) && rsp_valid && rsp_stall;

   `ASSERT_IMPLIES(a_pop_needs_item, clock, reset, q_pop, q_head.valid)
   `ASSERT_IMPLIES(a_newline_waits, clock, reset, nl_blocked, !q_pop)
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !q_head.valid)

endmodule

### design/accp_front.sv
// Input stage: accepts bytes, classifies them and feeds the queue.
module accp_front
   import accp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       push,
   output token_type  push_tok,
   input  logic       queue_full
);

   logic      fe_valid_ff, fe_valid_in;
   token_type fe_tok_ff, fe_tok_in;
   token_type cls_tok;
   logic      load;

   always_comb begin
      cls_tok.digit = req_rx_byte[3:0];
      for (int k = 0; k < HDR_LEN; k++) begin
         cls_tok.hdr_match[k] = (req_rx_byte == HDR_TEXT[k]);
      end
      if (req_rx_byte == CH_NUL) begin
         cls_tok.cls = CLS_RESTART;
      end else if (req_rx_byte == CH_NL) begin
         cls_tok.cls = CLS_NEWLINE;
      end else if (req_rx_byte == CH_COMMA) begin
         cls_tok.cls = CLS_COMMA;
      end else if (req_rx_byte == CH_SPACE ||
                   (req_rx_byte >= CH_TAB && req_rx_byte <= CH_CR)) begin
         cls_tok.cls = CLS_SPACE;
      end else if (req_rx_byte == CH_PLUS) begin
         cls_tok.cls = CLS_PLUS;
      end else if (req_rx_byte == CH_MINUS) begin
         cls_tok.cls = CLS_MINUS;
      end else if (req_rx_byte >= CH_ZERO && req_rx_byte <= CH_NINE) begin
         cls_tok.cls = CLS_DIGIT;
      end else begin
         cls_tok.cls = CLS_OTHER;
      end
   end

   assign req_stall = fe_valid_ff && queue_full;
   assign push      = fe_valid_ff && !queue_full;
   assign push_tok  = fe_tok_ff;
   assign load      = req_valid && !req_stall;

   always_comb begin
      fe_valid_in = fe_valid_ff;
      fe_tok_in   = fe_tok_ff;
      if (load) begin
         fe_valid_in = 1'b1;
         fe_tok_in   = cls_tok;
      end else if (push) begin
         fe_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fe_tok_ff <= fe_tok_in;
   end

endmodule

### design/accp_queue.sv
// Small item queue between the classifier and the parser.
module accp_queue
   import accp_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  token_type      push_tok,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   token_type       mem_ff [DEPTH];
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.tok   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

### design/accp_back.sv
// Parser stage: header check, token numbering, number accumulation, result register.
module accp_back
   import accp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_header_ok,
   output logic signed [31:0]  rsp_strategy_id,
   output logic signed [31:0]  rsp_kill_run,
   output logic signed [31:0]  rsp_yaw_value,
   output logic signed [31:0]  rsp_pitch_value,
   output logic signed [31:0]  rsp_roll_value
);

   logic [2:0]             hdr_pos_ff, hdr_pos_in;
   logic                   hdr_bad_ff, hdr_bad_in;
   logic [2:0]             tok_idx_ff, tok_idx_in;
   logic                   tok_started_ff, tok_started_in;
   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic                   seen_ff, seen_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            pend_ff [VALUE_COUNT];
   logic [31:0]            pend_in [VALUE_COUNT];
   logic [VALUE_COUNT-1:0] pend_valid_ff, pend_valid_in;
   logic [31:0]            held_ff [VALUE_COUNT];
   logic [31:0]            held_in [VALUE_COUNT];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;

   logic                   slot_free;
   logic                   is_nl;
   logic [35:0]            acc_wide;
   logic [35:0]            acc_next_wide;
   logic [31:0]            acc_digit;
   logic [31:0]            tok_val;
   logic                   ending;
   logic [VALUE_COUNT-1:0] hit;
   logic [2:0]             idx_after;
   logic                   line_ok;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_nl     = (head.tok.cls == CLS_NEWLINE);
   assign pop       = head.valid && (!is_nl || slot_free);

   // acc * 10 + digit, saturating at 2^31
   assign acc_wide      = {4'b0, acc_ff};
   assign acc_next_wide = (acc_wide << 3) + (acc_wide << 1) + 36'(head.tok.digit);
   assign acc_digit     = (acc_next_wide > 36'(SAT_NEG)) ? SAT_NEG : acc_next_wide[31:0];

   always_comb begin
      if (neg_ff) begin
         tok_val = (acc_ff >= SAT_NEG) ? SAT_NEG : (32'd0 - acc_ff);
      end else begin
         tok_val = (acc_ff > SAT_POS) ? SAT_POS : acc_ff;
      end
   end

   assign ending    = tok_started_ff && seen_ff;
   assign idx_after = tok_started_ff ? ((tok_idx_ff >= LAST_INDEX) ? 3'd0 : tok_idx_ff + 3'd1)
                                     : tok_idx_ff;
   assign line_ok   = (hdr_pos_ff == HDR_DONE) && !hdr_bad_ff;

   always_comb begin
      for (int i = 0; i < VALUE_COUNT; i++) begin
         hit[i] = ending && (tok_idx_ff == 3'(i + 1));
      end
   end

   always_comb begin
      hdr_pos_in     = hdr_pos_ff;
      hdr_bad_in     = hdr_bad_ff;
      tok_idx_in     = tok_idx_ff;
      tok_started_in = tok_started_ff;
      phase_in       = phase_ff;
      neg_in         = neg_ff;
      seen_in        = seen_ff;
      acc_in         = acc_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      held_in        = held_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;

      if (pop) begin
         if (head.tok.cls != CLS_RESTART && head.tok.cls != CLS_NEWLINE &&
             hdr_pos_ff < HDR_DONE) begin
            if (!head.tok.hdr_match[hdr_pos_ff]) begin
               hdr_bad_in = 1'b1;
            end
            hdr_pos_in = hdr_pos_ff + 3'd1;
         end

         unique case (head.tok.cls)
            CLS_RESTART, CLS_NEWLINE: begin
               if (is_nl) begin
                  for (int i = 0; i < VALUE_COUNT; i++) begin
                     if (line_ok && (pend_valid_ff[i] || hit[i])) begin
                        held_in[i] = hit[i] ? tok_val : pend_ff[i];
                     end
                  end
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = line_ok;
               end
               hdr_pos_in     = 3'd0;
               hdr_bad_in     = 1'b0;
               tok_idx_in     = 3'd0;
               pend_valid_in  = '0;
               tok_started_in = 1'b0;
               phase_in       = PH_SKIP;
               neg_in         = 1'b0;
               seen_in        = 1'b0;
               acc_in         = '0;
            end
            CLS_COMMA: begin
               for (int i = 0; i < VALUE_COUNT; i++) begin
                  if (hit[i]) begin
                     pend_in[i]       = tok_val;
                     pend_valid_in[i] = 1'b1;
                  end
               end
               tok_idx_in     = idx_after;
               tok_started_in = 1'b0;
               phase_in       = PH_SKIP;
               neg_in         = 1'b0;
               seen_in        = 1'b0;
               acc_in         = '0;
            end
            default: begin
               tok_started_in = 1'b1;
               unique case (phase_ff)
                  PH_SKIP: begin
                     case (head.tok.cls)
                        CLS_SPACE: begin
                        end
                        CLS_PLUS, CLS_MINUS: begin
                           neg_in   = (head.tok.cls == CLS_MINUS);
                           phase_in = PH_SIGN;
                        end
                        CLS_DIGIT: begin
                           acc_in   = acc_digit;
                           seen_in  = 1'b1;
                           phase_in = PH_DIGITS;
                        end
                        default: begin
                           phase_in = PH_DONE;
                        end
                     endcase
                  end
                  PH_SIGN, PH_DIGITS: begin
                     if (head.tok.cls == CLS_DIGIT) begin
                        acc_in   = acc_digit;
                        seen_in  = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff     <= 3'd0;
         hdr_bad_ff     <= 1'b0;
         tok_idx_ff     <= 3'd0;
         tok_started_ff <= 1'b0;
         phase_ff       <= PH_SKIP;
         neg_ff         <= 1'b0;
         seen_ff        <= 1'b0;
         acc_ff         <= '0;
         pend_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_ok_ff      <= 1'b0;
         for (int i = 0; i < VALUE_COUNT; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         hdr_pos_ff     <= hdr_pos_in;
         hdr_bad_ff     <= hdr_bad_in;
         tok_idx_ff     <= tok_idx_in;
         tok_started_ff <= tok_started_in;
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         seen_ff        <= seen_in;
         acc_ff         <= acc_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_ok_ff      <= rsp_ok_in;
         held_ff        <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   // held values change only at a newline, which waits for a free result slot
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_header_ok   = rsp_ok_ff;
   assign rsp_strategy_id = $signed(held_ff[0]);
   assign rsp_kill_run    = $signed(held_ff[1]);
   assign rsp_yaw_value   = $signed(held_ff[2]);
   assign rsp_pitch_value = $signed(held_ff[3]);
   assign rsp_roll_value  = $signed(held_ff[4]);

endmodule
